// File: sv/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// pre holding at an edge implies post at the same edge
`define ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// cond must never hold
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`else

`define ASSERT_IMP(lbl, clk, rst_n, pre, post, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// File: sv/lsc_pkg.sv
`default_nettype none

package lsc_pkg;

  localparam int COORD_WIDTH = 16;

  // window reset values
  localparam int WIN_X_MIN_RST = 0;
  localparam int WIN_Y_MIN_RST = 0;
  localparam int WIN_X_MAX_RST = 1023;
  localparam int WIN_Y_MAX_RST = 767;

  localparam int QUEUE_DEPTH = 8;
  localparam int CFG_IDX_W   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_MIN = 2'd0,
    REG_Y_MIN = 2'd1,
    REG_X_MAX = 2'd2,
    REG_Y_MAX = 2'd3
  } cfg_reg_e;

  // region code bits
  localparam logic [3:0] CODE_NONE  = 4'b0000;
  localparam logic [3:0] CODE_LEFT  = 4'b0001;
  localparam logic [3:0] CODE_RIGHT = 4'b0010;
  localparam logic [3:0] CODE_BELOW = 4'b0100;
  localparam logic [3:0] CODE_ABOVE = 4'b1000;

  // how an endpoint is moved onto the window
  typedef enum logic [2:0] {
    MV_NONE = 3'd0,
    MV_XMIN = 3'd1,
    MV_XMAX = 3'd2,
    MV_YMIN = 3'd3,
    MV_YMAX = 3'd4
  } move_e;

  // queue entry: accept flag plus two endpoint jobs of 5w+4 bits
  function automatic int entry_width(input int w);
    return 10 * w + 9;
  endfunction

  // divider lane latency: multiply, prepare, one stage per quotient bit, round off
  function automatic int div_latency(input int w);
    return w + 4;
  endfunction

endpackage

`default_nettype wire

// File: sv/lsc_front.sv
`default_nettype none

module lsc_front #(
  parameter int W = lsc_pkg::COORD_WIDTH
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire logic signed [W-1:0]    first_x_i,
  input  wire logic signed [W-1:0]    first_y_i,
  input  wire logic signed [W-1:0]    second_x_i,
  input  wire logic signed [W-1:0]    second_y_i,
  input  wire logic signed [W-1:0]    win_x_min_i,
  input  wire logic signed [W-1:0]    win_y_min_i,
  input  wire logic signed [W-1:0]    win_x_max_i,
  input  wire logic signed [W-1:0]    win_y_max_i,
  output logic                        push_o,
  output logic [lsc_pkg::entry_width(W)-1:0] entry_o,
  output logic [1:0]                  inflight_o
);

  localparam int PW = 2 * W + 2;

  // ---------------- stage 0: order, deltas, region codes
  logic signed [W:0] fx, fy, sx, sy, wxl, wyb, wxr, wyt;
  logic signed [W:0] ax_d, ay_d, bx_d, by_d;
  logic              swap;
  logic [3:0]        c1_d, c2_d;

  assign fx  = {first_x_i[W-1], first_x_i};
  assign fy  = {first_y_i[W-1], first_y_i};
  assign sx  = {second_x_i[W-1], second_x_i};
  assign sy  = {second_y_i[W-1], second_y_i};
  assign wxl = {win_x_min_i[W-1], win_x_min_i};
  assign wyb = {win_y_min_i[W-1], win_y_min_i};
  assign wxr = {win_x_max_i[W-1], win_x_max_i};
  assign wyt = {win_y_max_i[W-1], win_y_max_i};

  assign swap = fx > sx;
  assign ax_d = swap ? sx : fx;
  assign ay_d = swap ? sy : fy;
  assign bx_d = swap ? fx : sx;
  assign by_d = swap ? fy : sy;

  assign c1_d = {ay_d > wyt, ay_d < wyb, ax_d > wxr, ax_d < wxl};
  assign c2_d = {by_d > wyt, by_d < wyb, bx_d > wxr, bx_d < wxl};

  logic              v0_q;
  logic signed [W:0] ax0_q, ay0_q, bx0_q, by0_q;
  logic signed [W:0] dx0_q, dy0_q, dxl0_q, dxr0_q, dyb0_q, dyt0_q;
  logic signed [W:0] kxr0_q, kyb0_q, kyt0_q;
  logic [3:0]        c10_q, c20_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      ax0_q  <= ax_d;
      ay0_q  <= ay_d;
      bx0_q  <= bx_d;
      by0_q  <= by_d;
      dx0_q  <= bx_d - ax_d;
      dy0_q  <= by_d - ay_d;
      dxl0_q <= wxl - ax_d;
      dxr0_q <= wxr - ax_d;
      dyb0_q <= wyb - ay_d;
      dyt0_q <= wyt - ay_d;
      kxr0_q <= wxr - bx_d;
      kyb0_q <= wyb - by_d;
      kyt0_q <= wyt - by_d;
      c10_q  <= c1_d;
      c20_q  <= c2_d;
    end
  end

  // ---------------- stage 1: cross products for the slope tests
  logic                v1_q;
  logic signed [PW-1:0] p_dydxr_q, p_dxdyt_q, p_dxdyb_q, p_dydxl_q;
  logic signed [PW-1:0] p_dybdxr_q, p_dxldyt_q, p_dxldyb_q, p_dytdxr_q;
  logic signed [W:0]   ax1_q, ay1_q, bx1_q, by1_q;
  logic signed [W:0]   dx1_q, dy1_q, dxl1_q, dyb1_q, dyt1_q;
  logic signed [W:0]   kxr1_q, kyb1_q, kyt1_q;
  logic [3:0]          c11_q, c21_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v0_q) begin
      p_dydxr_q  <= dy0_q * dxr0_q;
      p_dxdyt_q  <= dx0_q * dyt0_q;
      p_dxdyb_q  <= dx0_q * dyb0_q;
      p_dydxl_q  <= dy0_q * dxl0_q;
      p_dybdxr_q <= dyb0_q * dxr0_q;
      p_dxldyt_q <= dxl0_q * dyt0_q;
      p_dxldyb_q <= dxl0_q * dyb0_q;
      p_dytdxr_q <= dyt0_q * dxr0_q;
      ax1_q  <= ax0_q;
      ay1_q  <= ay0_q;
      bx1_q  <= bx0_q;
      by1_q  <= by0_q;
      dx1_q  <= dx0_q;
      dy1_q  <= dy0_q;
      dxl1_q <= dxl0_q;
      dyb1_q <= dyb0_q;
      dyt1_q <= dyt0_q;
      kxr1_q <= kxr0_q;
      kyb1_q <= kyb0_q;
      kyt1_q <= kyt0_q;
      c11_q  <= c10_q;
      c21_q  <= c20_q;
    end
  end

  // ---------------- stage 2: edge selection
  logic le_r_t, lt_r_b, lt_t_l, lt_l_b, lt_r_t, lt_bl, lt_t_r, lt_b_r, lt_lr;
  logic dy_neg, dy_pos, c2_any;

  assign le_r_t = p_dydxr_q <= p_dxdyt_q;
  assign lt_r_b = p_dydxr_q <  p_dxdyb_q;
  assign lt_t_l = p_dxdyt_q <  p_dydxl_q;
  assign lt_l_b = p_dydxl_q <  p_dxdyb_q;
  assign lt_r_t = p_dydxr_q <  p_dxdyt_q;
  assign lt_bl  = p_dybdxr_q < p_dxldyt_q;
  assign lt_t_r = p_dxdyt_q <  p_dydxr_q;
  assign lt_b_r = p_dxdyb_q <  p_dydxr_q;
  assign lt_lr  = p_dxldyb_q < p_dytdxr_q;
  assign dy_neg = dy1_q[W];
  assign dy_pos = !dy1_q[W] && (dy1_q != '0);
  assign c2_any = c21_q != lsc_pkg::CODE_NONE;

  logic           acc;
  lsc_pkg::move_e pm, qm;

  always_comb begin
    acc = 1'b1;
    pm  = lsc_pkg::MV_NONE;
    qm  = lsc_pkg::MV_NONE;
    if ((c11_q & c21_q) != lsc_pkg::CODE_NONE) begin
      acc = 1'b0;
    end else begin
      unique case (c11_q)
        lsc_pkg::CODE_NONE: begin
          if (c2_any) begin
            if (!dy_neg) qm = le_r_t ? lsc_pkg::MV_XMAX : lsc_pkg::MV_YMAX;
            else         qm = lt_r_b ? lsc_pkg::MV_YMIN : lsc_pkg::MV_XMAX;
          end
        end
        lsc_pkg::CODE_LEFT: begin
          if (!c2_any) begin
            pm = lsc_pkg::MV_XMIN;
          end else if (!dy_neg) begin
            if (lt_t_l) begin
              acc = 1'b0;
            end else begin
              qm = le_r_t ? lsc_pkg::MV_XMAX : lsc_pkg::MV_YMAX;
              pm = lsc_pkg::MV_XMIN;
            end
          end else begin
            if (lt_l_b) begin
              acc = 1'b0;
            end else begin
              qm = lt_r_b ? lsc_pkg::MV_YMIN : lsc_pkg::MV_XMAX;
              pm = lsc_pkg::MV_XMIN;
            end
          end
        end
        lsc_pkg::CODE_BELOW: begin
          if (!c2_any) begin
            pm = lsc_pkg::MV_YMIN;
          end else if (dy_pos && !lt_r_b) begin
            qm = lt_r_t ? lsc_pkg::MV_XMAX : lsc_pkg::MV_YMAX;
            pm = lsc_pkg::MV_YMIN;
          end else begin
            acc = 1'b0;
          end
        end
        lsc_pkg::CODE_LEFT | lsc_pkg::CODE_BELOW: begin
          priority if (!dy_pos || lt_t_l || lt_r_b) begin
            acc = 1'b0;
          end else if (lt_bl) begin
            if (lt_l_b) begin
              pm = lsc_pkg::MV_YMIN;
              if (c21_q[1]) qm = lsc_pkg::MV_XMAX;
            end else begin
              pm = lsc_pkg::MV_XMIN;
              if (c2_any) qm = lt_r_t ? lsc_pkg::MV_XMAX : lsc_pkg::MV_YMAX;
            end
          end else if (lt_r_t) begin
            pm = lsc_pkg::MV_YMIN;
            if (c21_q[1]) qm = lsc_pkg::MV_XMAX;
          end else if (lt_l_b) begin
            pm = lsc_pkg::MV_YMIN;
            if (c2_any) qm = lsc_pkg::MV_YMAX;
          end else begin
            pm = lsc_pkg::MV_XMIN;
            if (c2_any) qm = lsc_pkg::MV_YMAX;
          end
        end
        lsc_pkg::CODE_ABOVE: begin
          if (!c2_any) begin
            pm = lsc_pkg::MV_YMAX;
          end else if (dy_neg && !lt_t_r) begin
            qm = lt_b_r ? lsc_pkg::MV_XMAX : lsc_pkg::MV_YMIN;
            pm = lsc_pkg::MV_YMAX;
          end else begin
            acc = 1'b0;
          end
        end
        lsc_pkg::CODE_LEFT | lsc_pkg::CODE_ABOVE: begin
          // top-left start with non-negative slope never reaches the window
          priority if (!dy_neg || lt_t_r || lt_l_b) begin
            acc = 1'b0;
          end else if (lt_lr) begin
            if (lt_t_l) begin
              pm = lsc_pkg::MV_YMAX;
              if (c21_q[1]) qm = lsc_pkg::MV_XMAX;
            end else begin
              pm = lsc_pkg::MV_XMIN;
              if (c2_any) qm = lt_b_r ? lsc_pkg::MV_XMAX : lsc_pkg::MV_YMIN;
            end
          end else if (lt_b_r) begin
            pm = lsc_pkg::MV_YMAX;
            if (c21_q[1]) qm = lsc_pkg::MV_XMAX;
          end else if (lt_t_l) begin
            pm = lsc_pkg::MV_YMAX;
            if (c2_any) qm = lsc_pkg::MV_YMIN;
          end else begin
            pm = lsc_pkg::MV_XMIN;
            if (c2_any) qm = lsc_pkg::MV_YMIN;
          end
        end
        // codes only an inverted window produces: pass through unchanged
        default: ;
      endcase
    end
  end

  // ---------------- divider operands for each endpoint
  logic [W-1:0] p_base, p_fix, q_base, q_fix;
  logic [W:0]   p_k, p_d, p_den, q_k, q_d, q_den;
  logic         p_isy, q_isy;

  always_comb begin
    p_base = ay1_q[W-1:0];
    p_k    = '0;
    p_d    = '0;
    p_den  = '0;
    p_fix  = ax1_q[W-1:0];
    p_isy  = 1'b1;
    unique case (pm)
      lsc_pkg::MV_XMIN: begin
        p_k = dxl1_q; p_d = dy1_q; p_den = dx1_q; p_fix = win_x_min_i;
      end
      lsc_pkg::MV_YMIN: begin
        p_base = ax1_q[W-1:0]; p_k = dyb1_q; p_d = dx1_q; p_den = dy1_q;
        p_fix = win_y_min_i; p_isy = 1'b0;
      end
      lsc_pkg::MV_YMAX: begin
        p_base = ax1_q[W-1:0]; p_k = dyt1_q; p_d = dx1_q; p_den = dy1_q;
        p_fix = win_y_max_i; p_isy = 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    q_base = by1_q[W-1:0];
    q_k    = '0;
    q_d    = '0;
    q_den  = '0;
    q_fix  = bx1_q[W-1:0];
    q_isy  = 1'b1;
    unique case (qm)
      lsc_pkg::MV_XMAX: begin
        q_k = kxr1_q; q_d = dy1_q; q_den = dx1_q; q_fix = win_x_max_i;
      end
      lsc_pkg::MV_YMIN: begin
        q_base = bx1_q[W-1:0]; q_k = kyb1_q; q_d = dx1_q; q_den = dy1_q;
        q_fix = win_y_min_i; q_isy = 1'b0;
      end
      lsc_pkg::MV_YMAX: begin
        q_base = bx1_q[W-1:0]; q_k = kyt1_q; q_d = dx1_q; q_den = dy1_q;
        q_fix = win_y_max_i; q_isy = 1'b0;
      end
      default: ;
    endcase
  end

  assign push_o     = v1_q;
  assign entry_o    = {acc, p_base, p_k, p_d, p_den, p_fix, p_isy,
                       q_base, q_k, q_d, q_den, q_fix, q_isy};
  assign inflight_o = {1'b0, v0_q} + {1'b0, v1_q};

endmodule

`default_nettype wire

// File: sv/lsc_queue.sv
`default_nettype none

module lsc_queue #(
  parameter int DW    = lsc_pkg::entry_width(lsc_pkg::COORD_WIDTH),
  parameter int DEPTH = lsc_pkg::QUEUE_DEPTH
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire logic [DW-1:0]              data_i,
  input  wire logic                       pop_i,
  output logic                            valid_o,
  output logic [DW-1:0]                   data_o,
  output logic [$clog2(DEPTH+1)-1:0]      count_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_q [DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  // pointers and fill count
  always_comb begin
    wr_d  = push_i ? wr_q + AW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + AW'(1) : rd_q;
    cnt_d = cnt_q + CW'(push_i) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];
  assign count_o = cnt_q;

endmodule

`default_nettype wire

// File: sv/lsc_div.sv
`default_nettype none

// base + round(k*d/den), ties away from zero, saturated; den == 0 keeps base.
module lsc_div #(
  parameter int W = lsc_pkg::COORD_WIDTH
) (
  input  wire logic               clk_i,
  input  wire logic [W-1:0]       base_i,
  input  wire logic signed [W:0]  k_i,
  input  wire logic signed [W:0]  d_i,
  input  wire logic signed [W:0]  den_i,
  output logic [W-1:0]            res_o
);

  localparam int MW = W + 1;
  localparam int PW = 2 * W + 2;
  localparam int NW = 2 * W + 3;
  localparam int QW = W + 1;
  localparam int RW = W + 2;
  localparam int SW = W + 3;

  // ---------------- magnitude product
  logic [MW-1:0] mk, md, mden;
  assign mk   = k_i[W]   ? MW'(-k_i)   : MW'(k_i);
  assign md   = d_i[W]   ? MW'(-d_i)   : MW'(d_i);
  assign mden = den_i[W] ? MW'(-den_i) : MW'(den_i);

  logic [PW-1:0] prod0_q;
  logic [MW-1:0] den0_q;
  logic          neg0_q, zero0_q;
  logic [W-1:0]  base0_q;

  always_ff @(posedge clk_i) begin
    prod0_q <= mk * md;
    den0_q  <= mden;
    neg0_q  <= k_i[W] ^ d_i[W] ^ den_i[W];
    zero0_q <= den_i == '0;
    base0_q <= base_i;
  end

  // ---------------- numerator with half divisor added, overflow guard
  logic [NW-1:0] num;
  logic [RW-1:0] d2;
  logic          ovf;
  assign num = {prod0_q, 1'b0} + NW'(den0_q);
  assign d2  = {den0_q, 1'b0};
  assign ovf = num[NW-1:QW] >= d2;

  logic [RW-1:0] rem_q  [QW+1];
  logic [QW-1:0] low_q  [QW+1];
  logic [QW-1:0] quo_q  [QW+1];
  logic [RW-1:0] d2_q   [QW+1];
  logic          ovf_q  [QW+1];
  logic          zero_q [QW+1];
  logic          neg_q  [QW+1];
  logic [W-1:0]  base_q [QW+1];

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= ovf ? '0 : num[NW-1:QW];
    low_q[0]  <= num[QW-1:0];
    quo_q[0]  <= '0;
    d2_q[0]   <= d2;
    ovf_q[0]  <= ovf;
    zero_q[0] <= zero0_q;
    neg_q[0]  <= neg0_q;
    base_q[0] <= base0_q;
  end

  // ---------------- restoring division, one quotient bit per stage
  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [RW:0] t;
    logic        ge;
    assign t  = {rem_q[s], low_q[s][QW-1-s]};
    assign ge = t >= {1'b0, d2_q[s]};

    always_ff @(posedge clk_i) begin
      rem_q[s+1]  <= ge ? RW'(t - {1'b0, d2_q[s]}) : t[RW-1:0];
      quo_q[s+1]  <= {quo_q[s][QW-2:0], ge};
      low_q[s+1]  <= low_q[s];
      d2_q[s+1]   <= d2_q[s];
      ovf_q[s+1]  <= ovf_q[s];
      zero_q[s+1] <= zero_q[s];
      neg_q[s+1]  <= neg_q[s];
      base_q[s+1] <= base_q[s];
    end
  end

  // ---------------- apply sign, saturate
  logic [QW-1:0]        qv;
  logic signed [SW-1:0] sb, sq, sum;
  logic                 in_range;
  logic [W-1:0]         sat;

  assign qv       = ovf_q[QW] ? '1 : quo_q[QW];
  assign sb       = {{3{base_q[QW][W-1]}}, base_q[QW]};
  assign sq       = {2'b00, qv};
  assign sum      = neg_q[QW] ? sb - sq : sb + sq;
  assign in_range = (sum[SW-1:W-1] == '0) || (sum[SW-1:W-1] == '1);
  assign sat      = in_range ? sum[W-1:0]
                  : (sum[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});

  always_ff @(posedge clk_i) begin
    res_o <= zero_q[QW] ? base_q[QW] : sat;
  end

endmodule

`default_nettype wire

// File: sv/lsc_back.sv
`default_nettype none

module lsc_back #(
  parameter int W = lsc_pkg::COORD_WIDTH
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             valid_i,
  input  wire logic [lsc_pkg::entry_width(W)-1:0] entry_i,
  output logic                                  done_o,
  output logic                                  accepted_o,
  output logic signed [W-1:0]                   clipped_left_x_o,
  output logic signed [W-1:0]                   clipped_left_y_o,
  output logic signed [W-1:0]                   clipped_right_x_o,
  output logic signed [W-1:0]                   clipped_right_y_o
);

  localparam int LAT = lsc_pkg::div_latency(W);
  localparam int SDW = 2 * W + 3;

  // unpack the queue entry
  logic         acc, p_isy, q_isy;
  logic [W-1:0] p_base, p_fix, q_base, q_fix;
  logic [W:0]   p_k, p_d, p_den, q_k, q_d, q_den;

  assign {acc, p_base, p_k, p_d, p_den, p_fix, p_isy,
          q_base, q_k, q_d, q_den, q_fix, q_isy} = entry_i;

  // one divider lane per endpoint
  logic [W-1:0] p_res, q_res;

  lsc_div #(.W(W)) u_div_p (
    .clk_i (clk_i),
    .base_i(p_base),
    .k_i   (p_k),
    .d_i   (p_d),
    .den_i (p_den),
    .res_o (p_res)
  );

  lsc_div #(.W(W)) u_div_q (
    .clk_i (clk_i),
    .base_i(q_base),
    .k_i   (q_k),
    .d_i   (q_d),
    .den_i (q_den),
    .res_o (q_res)
  );

  // side data follows the divider lanes
  logic           sv_q [LAT];
  logic [SDW-1:0] sd_q [LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) sv_q[i] <= 1'b0;
    end else begin
      sv_q[0] <= valid_i;
      for (int i = 1; i < LAT; i++) sv_q[i] <= sv_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    sd_q[0] <= {acc, p_fix, p_isy, q_fix, q_isy};
    for (int i = 1; i < LAT; i++) sd_q[i] <= sd_q[i-1];
  end

  logic         s_acc, s_pisy, s_qisy;
  logic [W-1:0] s_pfix, s_qfix;
  assign {s_acc, s_pfix, s_pisy, s_qfix, s_qisy} = sd_q[LAT-1];

  // output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= sv_q[LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    accepted_o        <= s_acc;
    clipped_left_x_o  <= !s_acc ? '0 : (s_pisy ? s_pfix : p_res);
    clipped_left_y_o  <= !s_acc ? '0 : (s_pisy ? p_res : s_pfix);
    clipped_right_x_o <= !s_acc ? '0 : (s_qisy ? s_qfix : q_res);
    clipped_right_y_o <= !s_acc ? '0 : (s_qisy ? q_res : s_qfix);
  end

endmodule

`default_nettype wire

// File: sv/line_segment_window_clipper.sv
// Channel   Direction  Handshake               Beat
// segment   in         start high, busy low    first_x_i, first_y_i, second_x_i, second_y_i
// result    out        done_o strobe, 1 cycle  accepted_o, clipped_left/right_x/y_o
// config    in         cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// One segment per cycle while busy is low; the divider lanes resolve one quotient bit per stage.
// Reset loads the default window and empties the pipeline and the queue.
// busy rises only when the queue between the classifier and the divider lanes
// could overflow; the divider lanes never stall, so in practice busy stays low.
`default_nettype none

`include "assert_macros.svh"

module line_segment_window_clipper #(
  parameter int COORD_WIDTH = lsc_pkg::COORD_WIDTH
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [COORD_WIDTH-1:0] first_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] first_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] second_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] second_y_i,
  output logic                               done_o,
  output logic                               accepted_o,
  output logic signed [COORD_WIDTH-1:0]      clipped_left_x_o,
  output logic signed [COORD_WIDTH-1:0]      clipped_left_y_o,
  output logic signed [COORD_WIDTH-1:0]      clipped_right_x_o,
  output logic signed [COORD_WIDTH-1:0]      clipped_right_y_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [lsc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [COORD_WIDTH-1:0]        cfg_wdata_i
);

  localparam int W     = COORD_WIDTH;
  localparam int EW    = lsc_pkg::entry_width(COORD_WIDTH);
  localparam int DEPTH = lsc_pkg::QUEUE_DEPTH;
  localparam int CW    = $clog2(DEPTH + 1);

  // window registers
  logic signed [W-1:0] win_x_min_q, win_y_min_q, win_x_max_q, win_y_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_x_min_q <= W'(lsc_pkg::WIN_X_MIN_RST);
      win_y_min_q <= W'(lsc_pkg::WIN_Y_MIN_RST);
      win_x_max_q <= W'(lsc_pkg::WIN_X_MAX_RST);
      win_y_max_q <= W'(lsc_pkg::WIN_Y_MAX_RST);
    end else if (cfg_we_i) begin
      unique case (lsc_pkg::cfg_reg_e'(cfg_idx_i))
        lsc_pkg::REG_X_MIN: win_x_min_q <= cfg_wdata_i;
        lsc_pkg::REG_Y_MIN: win_y_min_q <= cfg_wdata_i;
        lsc_pkg::REG_X_MAX: win_x_max_q <= cfg_wdata_i;
        lsc_pkg::REG_Y_MAX: win_y_max_q <= cfg_wdata_i;
      endcase
    end
  end

  logic          in_beat, push, q_valid;
  logic [EW-1:0] entry_in, entry_out;
  logic [1:0]    inflight;
  logic [CW-1:0] q_count;

  assign in_beat = start && !busy;
  assign busy    = ({1'b0, q_count} + (CW+1)'(inflight)) >= (CW+1)'(DEPTH - 1);

  lsc_front #(.W(W)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_beat),
    .first_x_i  (first_x_i),
    .first_y_i  (first_y_i),
    .second_x_i (second_x_i),
    .second_y_i (second_y_i),
    .win_x_min_i(win_x_min_q),
    .win_y_min_i(win_y_min_q),
    .win_x_max_i(win_x_max_q),
    .win_y_max_i(win_y_max_q),
    .push_o     (push),
    .entry_o    (entry_in),
    .inflight_o (inflight)
  );

  lsc_queue #(.DW(EW), .DEPTH(DEPTH)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (entry_in),
    .pop_i  (q_valid),
    .valid_o(q_valid),
    .data_o (entry_out),
    .count_o(q_count)
  );

  lsc_back #(.W(W)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (q_valid),
    .entry_i          (entry_out),
    .done_o           (done_o),
    .accepted_o       (accepted_o),
    .clipped_left_x_o (clipped_left_x_o),
    .clipped_left_y_o (clipped_left_y_o),
    .clipped_right_x_o(clipped_right_x_o),
    .clipped_right_y_o(clipped_right_y_o)
  );

  // a rejected beat carries zero coordinates
  `ASSERT_IMP(a_reject_zero, clk_i, rst_ni, done_o && !accepted_o, (clipped_left_x_o == '0) && (clipped_left_y_o == '0) && (clipped_right_x_o == '0) && (clipped_right_y_o == '0), "rejected result with nonzero coordinates")

  // the lanes drain one entry per cycle, so the queue never backs up into busy
  `ASSERT_NEVER(a_no_backup, clk_i, rst_ni, busy, "queue backed up")

endmodule

`default_nettype wire
